>>> rtl/text_terminal_cell_writer_assert.svh
// Assertion macros shared by the terminal cell writer RTL.
`ifndef TEXT_TERMINAL_CELL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CELL_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ttcw_pkg.sv
// Types and constants shared by the terminal cell writer modules.
package ttcw_pkg;

	typedef logic [15:0] cell_t;

	typedef enum logic [1:0] {
		ACT_PUT_CHAR = 2'd0,
		ACT_PUT_CELL = 2'd1,
		ACT_READ     = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam cell_t      BLANK_CELL   = 16'h0F20;
	localparam cell_t      ZERO_CELL    = 16'h0000;
	localparam logic [7:0] COLOR_RESET  = 8'd15;

endpackage

>>> rtl/ttcw_cell_ram.sv
// Single-port-write, single-port-read cell memory with registered read data.
module ttcw_cell_ram #(
	parameter int DEPTH = 2000
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  ttcw_pkg::cell_t            wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output ttcw_pkg::cell_t            rdata
);
	import ttcw_pkg::*;

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data is registered every cycle; a read of the address being written
	// returns the old contents, which the sequencer never relies on.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/text_terminal_cell_writer.sv
// Top level of the text terminal cell writer: sequencer, cursor and screen store.
//
// Text terminal engine holding a ROWS x COLUMNS store of 16-bit cells (character in
// the low byte, attribute in the high byte) in one memory with a single write port
// and a single registered read port, driven by a small sequencer. Every input beat
// produces exactly one result beat carrying the cell read (zero unless the action is
// a read) and the cursor position after the action. After reset the block runs a
// clearing pass that writes a white-on-black space to every cell and holds
// item_stall high until it is done; color_we writes are taken during that time as
// always. An ordinary beat passes through accept, address computation, memory
// access and result hand-off, and a read adds a step for the registered read data.
// A newline on the last row scrolls the store: the memory copies one cell per cycle
// up by one row, then zero-fills the last row. The block works on one beat at a
// time; item_stall stays high until the sequencer returns to idle, and the result
// sits in an output register so the next beat can be accepted while it waits for
// the consumer.
`include "text_terminal_cell_writer_assert.svh"

module text_terminal_cell_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        color_we,
	input  logic [7:0]                  color_wdata,

	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  action,
	input  logic [7:0]                  char_code,
	input  logic [7:0]                  cell_color,
	input  logic [$clog2(COLUMNS)-1:0]  col_x,
	input  logic [$clog2(ROWS)-1:0]     row_y,

	output logic                        result_valid,
	input  logic                        result_stall,
	output ttcw_pkg::cell_t             cell_value,
	output logic [$clog2(ROWS)-1:0]     cursor_row,
	output logic [$clog2(COLUMNS)-1:0]  cursor_col
);
	import ttcw_pkg::*;

	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY   = ADDR_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] FIRST_FILL  = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
	localparam logic [COL_W:0]    COL_LIMIT   = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W:0]    ROW_LIMIT   = (ROW_W + 1)'(ROWS);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_ADDR   = 8'b0000_0100,
		ST_EXEC   = 8'b0000_1000,
		ST_READ   = 8'b0001_0000,
		ST_SCROLL = 8'b0010_0000,
		ST_FILL   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [7:0]          color_q;
	logic [ROW_W-1:0]    row_pos_q;
	logic [COL_W-1:0]    col_pos_q;

	// Latched beat.
	action_t             act_q;
	logic [7:0]          char_q;
	logic [7:0]          attr_q;
	logic [COL_W-1:0]    col_x_q;
	logic [ROW_W-1:0]    row_y_q;

	logic [ADDR_W-1:0]   addr_q;
	cell_t               cell_q;

	// Scroll copy: a read is issued one cycle, its data written back the next.
	logic                copy_vld_s1;
	logic [ADDR_W-1:0]   copy_addr_s1;

	logic                result_valid_q;
	cell_t               cell_value_q;
	logic [ROW_W-1:0]    cursor_row_q;
	logic [COL_W-1:0]    cursor_col_q;

	logic                accept;
	logic                in_range;
	logic                out_free;
	logic [ROW_W-1:0]    row_sel;
	logic [COL_W-1:0]    col_sel;
	logic [ADDR_W-1:0]   addr_next;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	cell_t               ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	cell_t               ram_rdata;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	assign in_range = ({1'b0, col_x_q} < COL_LIMIT) && ({1'b0, row_y_q} < ROW_LIMIT);

	// Put-character addresses the cursor, the other actions the given position.
	assign row_sel   = (act_q == ACT_PUT_CHAR) ? row_pos_q : row_y_q;
	assign col_sel   = (act_q == ACT_PUT_CHAR) ? col_pos_q : col_x_q;
	assign addr_next = ADDR_W'(row_sel) * ROW_STRIDE + ADDR_W'(col_sel);

	// The read port looks one row ahead during a scroll, else at the item's cell.
	assign ram_raddr = (state_q == ST_SCROLL) ? (cnt_q + ROW_STRIDE) : addr_q;

	// One write per cycle; a pending scroll copy takes the port before the fill.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {attr_q, char_q};
		priority if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = BLANK_CELL;
		end else if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = ZERO_CELL;
		end else if (state_q == ST_EXEC) begin
			if (act_q == ACT_PUT_CHAR && char_q != NEWLINE_CODE) begin
				ram_we    = 1'b1;
				ram_wdata = {color_q, char_q};
			end else if (act_q == ACT_PUT_CELL && in_range) begin
				ram_we    = 1'b1;
			end
		end
	end

	ttcw_cell_ram #(
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The attribute register can be written in any state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (color_we) begin
			color_q <= color_wdata;
		end
	end

	// Beat capture, address and read data need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action_t'(action);
			char_q  <= char_code;
			attr_q  <= cell_color;
			col_x_q <= col_x;
			row_y_q <= row_y;
		end
		if (state_q == ST_ADDR) begin
			addr_q <= addr_next;
		end
		if (state_q == ST_EXEC) begin
			cell_q <= ZERO_CELL;
		end else if (state_q == ST_READ) begin
			cell_q <= ram_rdata;
		end
		copy_addr_s1 <= cnt_q;
	end

	// Sequencer and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (act_q)
						ACT_PUT_CHAR: begin
							if (char_q == NEWLINE_CODE) begin
								col_pos_q <= '0;
								if (row_pos_q == LAST_ROW) begin
									// Row pins at the bottom while the store moves up.
									cnt_q   <= '0;
									state_q <= ST_SCROLL;
								end else begin
									row_pos_q <= row_pos_q + 1'b1;
								end
							end else if (col_pos_q == LAST_COL) begin
								// Wrapping past the bottom goes back to the top row
								// without scrolling.
								col_pos_q <= '0;
								row_pos_q <= (row_pos_q == LAST_ROW) ? '0 : row_pos_q + 1'b1;
							end else begin
								col_pos_q <= col_pos_q + 1'b1;
							end
						end
						ACT_READ: begin
							if (in_range) begin
								state_q <= ST_READ;
							end
						end
						ACT_PUT_CELL, ACT_NONE: begin
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					if (cnt_q == LAST_COPY) begin
						cnt_q   <= FIRST_FILL;
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					// The last copy write owns the port for the first fill cycle.
					if (!copy_vld_s1) begin
						if (cnt_q == LAST_CELL) begin
							cnt_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds the result beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			cell_value_q <= cell_q;
			cursor_row_q <= row_pos_q;
			cursor_col_q <= col_pos_q;
		end
	end

	assign result_valid = result_valid_q;
	assign cell_value   = cell_value_q;
	assign cursor_row   = cursor_row_q;
	assign cursor_col   = cursor_col_q;

	`TTCW_ASSERT_NOW(a_col_in_range, 1'b1, col_pos_q < COLUMNS, "cursor column out of range")
	`TTCW_ASSERT_NOW(a_row_in_range, 1'b1, row_pos_q < ROWS, "cursor row out of range")
	`TTCW_ASSERT_NEXT(a_accept_to_addr, accept, state_q == ST_ADDR, "accepted beat not started")
	`TTCW_ASSERT_NOW(a_result_from_done, $rose(result_valid_q), $past(state_q == ST_DONE), "result without finished beat")

endmodule
